>>> rtl/core/mxdot_pkg.sv
// Shared types, constants and helper functions for the MX FP8 scaled dot unit.
`default_nettype none
package mxdot_pkg;

    localparam int unsigned SumW   = 72;   // signed exact sum of four lane products
    localparam int unsigned MagW   = 71;   // magnitude of that sum
    localparam int unsigned AddW   = 64;   // aligned adder datapath
    localparam int unsigned Stages = 8;

    localparam logic [31:0] QnanDefault = 32'h7FC0_0000;
    localparam logic [31:0] QnanNeg     = 32'hFFC0_0000;
    localparam logic [31:0] InfBits     = 32'h7F80_0000;
    localparam logic [7:0]  ScaleNan    = 8'hFF;
    localparam logic [7:0]  ExpMax      = 8'hFF;
    localparam logic [10:0] FactorBf    = 11'd32;
    localparam logic [10:0] FactorHf    = 11'd18;
    localparam logic [10:0] FactorMix   = 11'd25;

    typedef struct packed {
        logic [31:0] prod;
        logic [31:0] acc;
        logic        nan;
    } t_prod_res;

    // Index of the most significant set bit; zero when no bit is set.
    function automatic logic [6:0] msb_index(input logic [127:0] x);
        logic [6:0] idx;
        idx = '0;
        for (int i = 0; i < 128; i++) begin
            if (x[i]) begin
                idx = 7'(i);
            end
        end
        return idx;
    endfunction

    // Drop denormals to a zero of the same sign.
    function automatic logic [31:0] daz(input logic [31:0] v);
        return (v[30:23] == 8'd0) ? {v[31], 31'd0} : v;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/mx_fp8_scaled_dot_fp32_accumulate.sv
// Top level of the MX FP8 scaled dot product with FP32 accumulate.
//
//   channel | signals                                     | direction
//   input   | i_valid, o_stall, i_accumulator..i_b_is_e5m2 | into block
//   output  | o_valid, i_stall, o_new_accumulator          | out of block
//
// One item per cycle while the output is not stalled.
// Stages: decode/multiply, sum, leading-one, round, compare, align/add, leading-one, round.
// The whole pipeline holds while a result waits under stall, bubbles included.
// Reset clears only the valid bits.
`default_nettype none
module mx_fp8_scaled_dot_fp32_accumulate
    import mxdot_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_accumulator,
    input  wire logic [31:0] i_a_quad,
    input  wire logic [31:0] i_b_quad,
    input  wire logic [7:0]  i_a_scale,
    input  wire logic [7:0]  i_b_scale,
    input  wire logic        i_a_is_e5m2,
    input  wire logic        i_b_is_e5m2,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_new_accumulator
);

    logic [Stages-1:0] r_v;
    logic              en;
    t_prod_res         prod_res;

    assign en      = !(r_v[Stages-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_v[Stages-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[Stages-2:0], i_valid};
        end
    end

    mxdot_prod u_prod (
        .i_clk         (i_clk),
        .i_en          (en),
        .i_accumulator (i_accumulator),
        .i_a_quad      (i_a_quad),
        .i_b_quad      (i_b_quad),
        .i_a_scale     (i_a_scale),
        .i_b_scale     (i_b_scale),
        .i_a_is_e5m2   (i_a_is_e5m2),
        .i_b_is_e5m2   (i_b_is_e5m2),
        .o_res         (prod_res)
    );

    mxdot_add u_add (
        .i_clk (i_clk),
        .i_en  (en),
        .i_res (prod_res),
        .o_sum (o_new_accumulator)
    );

endmodule
`default_nettype wire

>>> rtl/core/mxdot_prod.sv
// Four-lane FP8 product sum, converted to a scaled FP32 value over four stages.
`default_nettype none
module mxdot_prod
    import mxdot_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_accumulator,
    input  wire logic [31:0] i_a_quad,
    input  wire logic [31:0] i_b_quad,
    input  wire logic [7:0]  i_a_scale,
    input  wire logic [7:0]  i_b_scale,
    input  wire logic        i_a_is_e5m2,
    input  wire logic        i_b_is_e5m2,
    output t_prod_res        o_res
);

    // Stage 1: decoded, shifted and signed lane terms.
    logic [SumW-1:0] r_term [4];
    logic [SumW-1:0] n_term [4];
    logic [31:0]     r_acc1, r_acc2, r_acc3;
    logic [10:0]     r_adj1, r_adj2, r_adj3, n_adj;
    logic            r_nan1, r_nan2, r_nan3;

    always_comb begin
        logic [7:0] ba, bb;
        logic [3:0] ma, mb;
        logic [4:0] ea, eb, sa, sb;
        logic [7:0] pr;
        logic [5:0] sh;
        logic [67:0] t;
        for (int k = 0; k < 4; k++) begin
            ba = i_a_quad[8*k +: 8];
            bb = i_b_quad[8*k +: 8];
            if (i_a_is_e5m2) begin
                ea = 5'(ba[6:2]);
                ma = (ea != 5'd0) ? {2'b01, ba[1:0]} : {2'b00, ba[1:0]};
            end else begin
                ea = {1'b0, ba[6:3]};
                ma = (ea != 5'd0) ? {1'b1, ba[2:0]} : {1'b0, ba[2:0]};
            end
            if (i_b_is_e5m2) begin
                eb = 5'(bb[6:2]);
                mb = (eb != 5'd0) ? {2'b01, bb[1:0]} : {2'b00, bb[1:0]};
            end else begin
                eb = {1'b0, bb[6:3]};
                mb = (eb != 5'd0) ? {1'b1, bb[2:0]} : {1'b0, bb[2:0]};
            end
            sa = (ea != 5'd0) ? ea - 5'd1 : 5'd0;
            sb = (eb != 5'd0) ? eb - 5'd1 : 5'd0;
            pr = ma * mb;
            sh = {1'b0, sa} + {1'b0, sb};
            t  = 68'(pr) << sh;
            n_term[k] = (ba[7] ^ bb[7]) ? -{4'd0, t} : {4'd0, t};
        end
    end

    always_comb begin
        logic [10:0] factor;
        if (i_a_is_e5m2 && i_b_is_e5m2) begin
            factor = FactorBf;
        end else if (!i_a_is_e5m2 && !i_b_is_e5m2) begin
            factor = FactorHf;
        end else begin
            factor = FactorMix;
        end
        n_adj = 11'(i_a_scale) + 11'(i_b_scale) - 11'd254 - factor;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_term <= n_term;
            r_acc1 <= i_accumulator;
            r_adj1 <= n_adj;
            r_nan1 <= (i_a_scale == ScaleNan) || (i_b_scale == ScaleNan);
        end
    end

    // Stage 2: exact sum and its magnitude.
    logic [MagW-1:0] r_mag2, r_mag3;
    logic            r_sign2, r_sign3;
    logic [SumW-1:0] n_sum;
    assign n_sum = r_term[0] + r_term[1] + r_term[2] + r_term[3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sign2 <= n_sum[SumW-1];
            r_mag2  <= n_sum[SumW-1] ? MagW'(-n_sum) : MagW'(n_sum);
            r_acc2  <= r_acc1;
            r_adj2  <= r_adj1;
            r_nan2  <= r_nan1;
        end
    end

    // Stage 3: leading one position.
    logic [6:0] r_p3;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p3    <= msb_index(128'(r_mag2));
            r_mag3  <= r_mag2;
            r_sign3 <= r_sign2;
            r_acc3  <= r_acc2;
            r_adj3  <= r_adj2;
            r_nan3  <= r_nan2;
        end
    end

    // Stage 4: normalize, round to nearest even, rebias and pack.
    t_prod_res r_res4;
    logic [31:0] n_prod;
    always_comb begin
        logic [MagW-1:0] norm;
        logic [24:0]     m;
        logic            g, st, rnd;
        logic [10:0]     biased;
        norm   = r_mag3 << (7'(MagW - 1) - r_p3);
        g      = norm[MagW-25];
        st     = |norm[MagW-26:0];
        rnd    = g && (norm[MagW-24] || st);
        m      = {1'b0, norm[MagW-1:MagW-24]} + 25'(rnd);
        biased = 11'd127 + 11'(r_p3) + r_adj3 + 11'(m[24]);
        if (r_mag3 == '0) begin
            n_prod = 32'd0;
        end else if ($signed(biased) > $signed(11'd254)) begin
            n_prod = {r_sign3, 31'd0} | InfBits;
        end else if ($signed(biased) <= $signed(11'd0)) begin
            n_prod = {r_sign3, 31'd0};
        end else begin
            n_prod = {r_sign3, biased[7:0], m[22:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res4.prod <= n_prod;
            r_res4.acc  <= r_acc3;
            r_res4.nan  <= r_nan3;
        end
    end

    assign o_res = r_res4;

endmodule
`default_nettype wire

>>> rtl/core/mxdot_add.sv
// FP32 adder with flush-to-zero and round to nearest even, four stages.
`default_nettype none
module mxdot_add
    import mxdot_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire t_prod_res   i_res,
    output logic [31:0]      o_sum
);

    // Stage 5: specials, magnitude order and exponent difference.
    logic        r_spec5, r_sub5, r_sign5, r_nan5;
    logic [31:0] r_sval5;
    logic [7:0]  r_ea5, r_diff5;
    logic [23:0] r_ma5, r_mb5;
    logic        n_spec;
    logic [31:0] n_sval, n_big, n_small;

    always_comb begin
        logic [31:0] a, b;
        logic [7:0]  ea, eb;
        a = daz(i_res.acc);
        b = daz(i_res.prod);
        ea = a[30:23];
        eb = b[30:23];
        n_spec = 1'b1;
        n_sval = a;
        if (ea == ExpMax && a[22:0] != 23'd0) begin
            n_sval = a | 32'h0040_0000;
        end else if (eb == ExpMax && b[22:0] != 23'd0) begin
            n_sval = b | 32'h0040_0000;
        end else if (ea == ExpMax) begin
            n_sval = (eb == ExpMax && (a[31] ^ b[31])) ? QnanNeg : a;
        end else if (eb == ExpMax) begin
            n_sval = b;
        end else if (ea == 8'd0 && eb == 8'd0) begin
            n_sval = a & b;
        end else if (ea == 8'd0) begin
            n_sval = b;
        end else if (eb == 8'd0) begin
            n_sval = a;
        end else begin
            n_spec = 1'b0;
        end
        if (a[30:0] < b[30:0]) begin
            n_big = b; n_small = a;
        end else begin
            n_big = a; n_small = b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_spec5 <= n_spec;
            r_sval5 <= n_sval;
            r_nan5  <= i_res.nan;
            r_sign5 <= n_big[31];
            r_sub5  <= n_big[31] ^ n_small[31];
            r_ea5   <= n_big[30:23];
            r_diff5 <= n_big[30:23] - n_small[30:23];
            r_ma5   <= {1'b1, n_big[22:0]};
            r_mb5   <= {1'b1, n_small[22:0]};
        end
    end

    // Stage 6: align and add.
    logic [AddW-1:0] r_s6, n_s;
    logic            r_spec6, r_sign6, r_nan6;
    logic [31:0]     r_sval6;
    logic [7:0]      r_ea6;

    always_comb begin
        logic [AddW-1:0] sa, mb, sbv;
        sa  = AddW'(r_ma5) << 39;
        mb  = AddW'(r_mb5) << 39;
        sbv = (r_diff5 <= 8'd39) ? (mb >> r_diff5) : AddW'(1);
        n_s = r_sub5 ? sa - sbv : sa + sbv;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s6    <= n_s;
            r_spec6 <= r_spec5;
            r_sval6 <= r_sval5;
            r_nan6  <= r_nan5;
            r_sign6 <= r_sign5;
            r_ea6   <= r_ea5;
        end
    end

    // Stage 7: leading one position.
    logic [AddW-1:0] r_s7;
    logic [6:0]      r_q7;
    logic            r_spec7, r_sign7, r_nan7;
    logic [31:0]     r_sval7;
    logic [7:0]      r_ea7;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q7    <= msb_index(128'(r_s6));
            r_s7    <= r_s6;
            r_spec7 <= r_spec6;
            r_sval7 <= r_sval6;
            r_nan7  <= r_nan6;
            r_sign7 <= r_sign6;
            r_ea7   <= r_ea6;
        end
    end

    // Stage 8: normalize, round and select the final value.
    logic [31:0] r_sum8, n_sum;
    always_comb begin
        logic [AddW-1:0] norm;
        logic [24:0]     m;
        logic            g, st, rnd;
        logic [9:0]      er;
        norm = r_s7 << (7'(AddW - 1) - r_q7);
        g    = norm[AddW-25];
        st   = |norm[AddW-26:0];
        rnd  = g && (norm[AddW-24] || st);
        m    = {1'b0, norm[AddW-1:AddW-24]} + 25'(rnd);
        er   = 10'(r_ea7) + 10'(r_q7) - 10'd62;
        if (r_nan7) begin
            n_sum = QnanDefault;
        end else if (r_spec7) begin
            n_sum = r_sval7;
        end else if (r_s7 == '0) begin
            n_sum = 32'd0;
        end else if ($signed(er) <= $signed(10'd0)) begin
            n_sum = {r_sign7, 31'd0};
        end else begin
            er = er + 10'(m[24]);
            if ($signed(er) >= $signed(10'd255)) begin
                n_sum = {r_sign7, 31'd0} | InfBits;
            end else begin
                n_sum = {r_sign7, er[7:0], m[24] ? m[23:1] : m[22:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum8 <= n_sum;
        end
    end

    assign o_sum = r_sum8;

endmodule
`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for the MX FP8 scaled dot product with FP32 accumulate.
`timescale 1ns / 100ps
module tb_top;
    import mxdot_pkg::*;

    typedef struct {
        logic [31:0] acc;
        logic [31:0] aq;
        logic [31:0] bq;
        logic [7:0]  asc;
        logic [7:0]  bsc;
        logic        abf;
        logic        bbf;
    } dot_item_t;

    localparam int NumRandom = 1300;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_accumulator;
    logic [31:0] i_a_quad;
    logic [31:0] i_b_quad;
    logic [7:0]  i_a_scale;
    logic [7:0]  i_b_scale;
    logic        i_a_is_e5m2;
    logic        i_b_is_e5m2;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_new_accumulator;

    dot_item_t   pending_items[$];
    logic [31:0] expected_acc[$];
    dot_item_t   on_bus;
    int          total_items;
    int          sent_count;
    int          mismatches;

    mx_fp8_scaled_dot_fp32_accumulate dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Exact fixed-point decode of one FP8 byte; the top exponent is a normal one.
    function automatic void fp8_unpack(input logic [7:0] b, input logic bf,
                                       output logic [3:0] m, output int unsigned sh,
                                       output logic neg);
        logic [4:0] e;
        neg = b[7];
        if (bf) begin
            e = {1'b0, b[6:2]};
            m = (e != 0) ? {2'b01, b[1:0]} : {2'b00, b[1:0]};
        end else begin
            e = {1'b0, b[6:3]};
            m = (e != 0) ? {1'b1, b[2:0]} : {1'b0, b[2:0]};
        end
        sh = (e != 0) ? e - 1 : 0;
    endfunction

    function automatic logic [31:0] sum_to_f32(input logic [127:0] x, input int adjust);
        logic [127:0] mag;
        logic         sign;
        logic [24:0]  mant;
        logic         g;
        logic         st;
        int           p;
        int           r;
        int           biased;
        if (x == 0) return 32'd0;
        sign = x[127];
        mag = sign ? -x : x;
        p = 0;
        for (int i = 0; i < 128; i++) begin
            if (mag[i]) p = i;
        end
        if (p > 23) begin
            r = p - 23;
            mant = 25'((mag >> r) & 128'hFF_FFFF);
            g = mag[r-1];
            st = (mag & ((128'd1 << (r - 1)) - 128'd1)) != 0;
            if (g && (mant[0] || st)) mant = mant + 25'd1;
        end else begin
            mant = 25'(mag << (23 - p));
        end
        biased = 127 + p + adjust + int'(mant[24]);
        if (biased > 254) return {sign, 31'h7F80_0000};
        if (biased <= 0) return {sign, 31'd0};
        return {sign, 8'(biased), mant[22:0]};
    endfunction

    function automatic logic [31:0] flush_denorm(input logic [31:0] v);
        return (v[30:23] == 8'd0) ? {v[31], 31'd0} : v;
    endfunction

    function automatic logic [31:0] f32_add(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] t;
        logic [7:0]  ea;
        logic [7:0]  eb;
        logic [63:0] sa;
        logic [63:0] sb;
        logic [63:0] s;
        logic [63:0] mant;
        int          diff;
        int          q;
        int          er;
        a = flush_denorm(x);
        b = flush_denorm(y);
        ea = a[30:23];
        eb = b[30:23];
        if (ea == 8'hFF && a[22:0] != 0) return a | 32'h0040_0000;
        if (eb == 8'hFF && b[22:0] != 0) return b | 32'h0040_0000;
        if (ea == 8'hFF) begin
            if (eb == 8'hFF && (a[31] != b[31])) return QnanNeg;
            return a;
        end
        if (eb == 8'hFF) return b;
        if (ea == 0 && eb == 0) return a & b;
        if (ea == 0) return b;
        if (eb == 0) return a;
        if (a[30:0] < b[30:0]) begin
            t = a; a = b; b = t;
            ea = a[30:23];
            eb = b[30:23];
        end
        sa = {40'd1, a[22:0]} << 39;
        sb = {40'd1, b[22:0]} << 39;
        diff = int'(ea) - int'(eb);
        sb = (diff <= 39) ? (sb >> diff) : 64'd1;
        s = (a[31] != b[31]) ? sa - sb : sa + sb;
        if (s == 0) return 32'd0;
        q = 0;
        for (int i = 0; i < 64; i++) begin
            if (s[i]) q = i;
        end
        er = int'(ea) + q - 62;
        if (er <= 0) return {a[31], 31'd0};
        if (q > 23) begin
            mant = s >> (q - 23);
            if (s[q-24] && (mant[0] || (s & ((64'd1 << (q - 24)) - 64'd1)) != 0))
                mant = mant + 64'd1;
            if (mant[24]) begin
                mant = mant >> 1;
                er++;
            end
        end else begin
            mant = s << (23 - q);
        end
        if (er >= 255) return {a[31], 31'h7F80_0000};
        return {a[31], 8'(er), mant[22:0]};
    endfunction

    function automatic logic [31:0] scaled_dot_accumulate(input dot_item_t it);
        logic [127:0] total;
        logic [127:0] term;
        logic [3:0]   ma;
        logic [3:0]   mb;
        logic         na;
        logic         nb;
        int unsigned  sha;
        int unsigned  shb;
        int           factor;
        if (it.asc == ScaleNan || it.bsc == ScaleNan) return QnanDefault;
        total = '0;
        for (int k = 0; k < 4; k++) begin
            fp8_unpack(it.aq[8*k +: 8], it.abf, ma, sha, na);
            fp8_unpack(it.bq[8*k +: 8], it.bbf, mb, shb, nb);
            term = (128'(ma) * 128'(mb)) << (sha + shb);
            total = (na != nb) ? total - term : total + term;
        end
        factor = (it.abf && it.bbf) ? int'(FactorBf) :
                 (!it.abf && !it.bbf) ? int'(FactorHf) : int'(FactorMix);
        return f32_add(it.acc, sum_to_f32(total, int'(it.asc) + int'(it.bsc) - 254 - factor));
    endfunction

    function automatic int idle_pct(input bit rx_side);
        int ph;
        ph = (total_items == 0) ? 0 : sent_count * 4 / total_items;
        case (ph)
            1: return rx_side ? 0 : 77;
            2: return rx_side ? 77 : 0;
            3: return 16;
            default: return 0;
        endcase
    endfunction

    function automatic dot_item_t make_item(input logic [31:0] acc, input logic [31:0] aq,
                                            input logic [31:0] bq, input logic [7:0] asc,
                                            input logic [7:0] bsc, input logic abf,
                                            input logic bbf);
        dot_item_t it;
        it.acc = acc; it.aq = aq; it.bq = bq;
        it.asc = asc; it.bsc = bsc; it.abf = abf; it.bbf = bbf;
        return it;
    endfunction

    // Sender: a transfer completes on valid without stall; a fresh item may replace it.
    always @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            expected_acc.push_back(scaled_dot_accumulate(on_bus));
        end
        if (!i_valid || !o_stall) begin
            if (i_rst_n && pending_items.size() > 0 && $urandom_range(99) >= idle_pct(0)) begin
                on_bus = pending_items.pop_front();
                sent_count++;
                i_accumulator <= on_bus.acc;
                i_a_quad      <= on_bus.aq;
                i_b_quad      <= on_bus.bq;
                i_a_scale     <= on_bus.asc;
                i_b_scale     <= on_bus.bsc;
                i_a_is_e5m2   <= on_bus.abf;
                i_b_is_e5m2   <= on_bus.bbf;
                i_valid       <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (o_valid && !i_stall) begin
            if (expected_acc.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", o_new_accumulator);
            end else begin
                logic [31:0] want;
                want = expected_acc.pop_front();
                if (o_new_accumulator !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("new_accumulator mismatch: expected %h, got %h",
                                 want, o_new_accumulator);
                end
            end
        end
        i_stall <= i_rst_n && ($urandom_range(99) < idle_pct(1));
    end

    initial begin
        int   ex;
        logic [7:0] sa;
        logic [7:0] sb;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_accumulator = '0;
        i_a_quad = '0;
        i_b_quad = '0;
        i_a_scale = '0;
        i_b_scale = '0;
        i_a_is_e5m2 = 1'b0;
        i_b_is_e5m2 = 1'b0;
        sent_count = 0;
        mismatches = 0;
        total_items = 0;

        // Directed cases: NaN scales, zeros, denormal and special accumulators,
        // cancellation, overflow and underflow of the scaled sum, format extremes.
        pending_items.push_back(make_item(32'h3F80_0000, 32'h3838_3838, 32'h3838_3838,
                                          ScaleNan, 8'd127, 0, 0));
        pending_items.push_back(make_item(32'h7FA0_0000, 32'h3C3C_3C3C, 32'h3C3C_3C3C,
                                          8'd127, ScaleNan, 1, 1));
        pending_items.push_back(make_item(32'h4040_0000, 32'h0, 32'hFFFF_FFFF,
                                          8'd127, 8'd127, 0, 0));
        pending_items.push_back(make_item(32'h0000_0001, 32'h0, 32'h0, 8'd127, 8'd127, 0, 1));
        pending_items.push_back(make_item(32'h8000_0001, 32'h0, 32'h0, 8'd127, 8'd127, 1, 0));
        pending_items.push_back(make_item(32'h8000_0000, 32'h0, 32'h0, 8'd127, 8'd127, 1, 1));
        pending_items.push_back(make_item(32'h0040_0000, 32'h38, 32'h38, 8'd127, 8'd127, 0, 0));
        pending_items.push_back(make_item(32'h7FA0_0000, 32'h38, 32'h38, 8'd127, 8'd127, 0, 0));
        pending_items.push_back(make_item(32'hFF80_0000, 32'h7F7F_7F7F, 32'h7F7F_7F7F,
                                          8'd254, 8'd254, 0, 0));
        pending_items.push_back(make_item(32'h7F80_0000, 32'hFFFF_FFFF, 32'h7F7F_7F7F,
                                          8'd254, 8'd254, 1, 1));
        pending_items.push_back(make_item(32'hBF80_0000, 32'h38, 32'h38, 8'd127, 8'd127, 0, 0));
        pending_items.push_back(make_item(32'h3F80_0000, 32'h3C, 32'hBC, 8'd127, 8'd127, 1, 1));
        pending_items.push_back(make_item(32'h0, 32'h0101_0101, 32'h0101_0101, 8'd0, 8'd0, 0, 1));
        pending_items.push_back(make_item(32'h3F80_0000, 32'h7F7F_7F7F, 32'h7F7F_7F7F,
                                          8'd0, 8'd0, 0, 0));
        pending_items.push_back(make_item(32'h7F7F_FFFF, 32'h7B7B_7B7B, 32'h7B7B_7B7B,
                                          8'd200, 8'd160, 1, 0));
        pending_items.push_back(make_item(32'hFF7F_FFFF, 32'hFFFF_FFFF, 32'h7F7F_7F7F,
                                          8'd254, 8'd127, 0, 1));
        pending_items.push_back(make_item(32'h3F80_0000, 32'h0180_0180, 32'h0101_8181,
                                          8'd127, 8'd127, 1, 1));
        pending_items.push_back(make_item(32'h0080_0000, 32'h3838_B838, 32'h3838_3838,
                                          8'd127, 8'd127, 0, 0));
        pending_items.push_back(make_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                          8'd0, 8'd254, 1, 0));

        for (int n = 0; n < NumRandom; n++) begin
            dot_item_t it;
            it.aq = $urandom();
            it.bq = $urandom();
            it.abf = $urandom_range(1);
            it.bbf = $urandom_range(1);
            if ($urandom_range(9) == 0) begin
                sa = $urandom_range(255);
                sb = $urandom_range(255);
            end else begin
                sa = $urandom_range(145, 105);
                sb = $urandom_range(145, 105);
            end
            it.asc = sa;
            it.bsc = sb;
            // Keep the accumulator near the product's magnitude most of the time.
            if ($urandom_range(3) == 0) begin
                it.acc = $urandom();
            end else begin
                ex = int'(sa) + int'(sb) - 127 + $urandom_range(16) - 8;
                if (ex < 1) ex = 1;
                if (ex > 254) ex = 254;
                it.acc = {1'($urandom_range(1)), 8'(ex), 23'($urandom())};
            end
            pending_items.push_back(it);
        end
        total_items = pending_items.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (pending_items.size() != 0 || i_valid || expected_acc.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && expected_acc.size() == 0)
            $display("mx_fp8_scaled_dot_fp32_accumulate regression: pass");
        else
            $display("mx_fp8_scaled_dot_fp32_accumulate regression: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("mx_fp8_scaled_dot_fp32_accumulate regression: fail");
        $finish;
    end

endmodule
